[src/scc_pkg.sv]
// Shared types and constants for the strongly connected component counter.
`default_nettype none
package scc_pkg;
  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int EIDX_W    = $clog2(MAX_EDGES);
  localparam int LINK_W    = EIDX_W + 1;
  localparam int CNT_W     = NODE_W + 1;
  localparam int ENTRY_W   = LINK_W + NODE_W;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [EIDX_W-1:0]  eidx_t;
  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  localparam link_t NULL_LINK = link_t'(MAX_EDGES);

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // Requests from the sequencer to the graph memories.
  typedef struct packed {
    logic   oh_we;
    logic   ih_we;
    node_t  oh_waddr;
    node_t  ih_waddr;
    link_t  head_wdata;
    node_t  oh_raddr;
    node_t  ih_raddr;
    logic   sr_we;
    logic   sf_we;
    node_t  seen_waddr;
    logic   seen_wdata;
    node_t  seen_raddr;
    logic   edge_we;
    eidx_t  edge_waddr;
    entry_t fwd_wdata;
    entry_t rev_wdata;
    eidx_t  edge_raddr;
    logic   fin_we;
    node_t  fin_waddr;
    node_t  fin_wdata;
    node_t  fin_raddr;
    logic   stk_we;
    node_t  stk_waddr;
    entry_t stk_wdata;
    node_t  stk_raddr;
  } mem_req_t;

  // Registered read data coming back from the memories.
  typedef struct packed {
    link_t  oh_q;
    link_t  ih_q;
    logic   sr_q;
    logic   sf_q;
    entry_t fwd_q;
    entry_t rev_q;
    node_t  fin_q;
    entry_t stk_q;
  } mem_rsp_t;
endpackage
`default_nettype wire

[src/scc_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/scc_ctrl.sv]
// Sequencer: edge loading, both depth-first passes, result and clearing pass.
`default_nettype none
module scc_ctrl import scc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       opcode,
  input  wire cnt_t       edge_from,
  input  wire cnt_t       edge_to,
  input  wire cnt_t       n,
  input  wire logic       res_ready,
  output logic            res_valid,
  output cnt_t            res_count,
  output logic [1:0]      res_status,
  output mem_req_t        req,
  input  wire mem_rsp_t   rsp
);
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_ADD    = 4'd2;
  localparam logic [3:0] ST_RSCAN  = 4'd3;
  localparam logic [3:0] ST_RSTART = 4'd4;
  localparam logic [3:0] ST_STEP   = 4'd5;
  localparam logic [3:0] ST_EDGE   = 4'd6;
  localparam logic [3:0] ST_CHK    = 4'd7;
  localparam logic [3:0] ST_POP    = 4'd8;
  localparam logic [3:0] ST_FSCAN  = 4'd9;
  localparam logic [3:0] ST_FREAD  = 4'd10;
  localparam logic [3:0] ST_FSTART = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0] state, state_next;
  node_t      clr_addr, clr_addr_next;
  link_t      edge_count, edge_count_next;
  logic [1:0] drop_flags, drop_flags_next;
  node_t      add_f, add_f_next, add_t, add_t_next;
  cnt_t       scan_i, scan_i_next;
  cnt_t       fin, fin_next;
  cnt_t       cnt, cnt_next;
  logic       dir, dir_next;   // high for the reverse pass
  cnt_t       depth, depth_next;
  node_t      top_node, top_node_next;
  link_t      top_ptr, top_ptr_next;
  node_t      cur_t, cur_t_next;

  cnt_t   from_m1, to_m1;
  logic   bad_node;
  entry_t edge_q;
  logic   seen_q;
  link_t  head_q;
  cnt_t   depth_m2;

  assign from_m1  = edge_from - cnt_t'(1);
  assign to_m1    = edge_to - cnt_t'(1);
  assign bad_node = (edge_from == '0) || (edge_from > n) || (edge_to == '0) || (edge_to > n);
  assign edge_q   = dir ? rsp.rev_q : rsp.fwd_q;
  assign seen_q   = dir ? rsp.sr_q : rsp.sf_q;
  assign head_q   = dir ? rsp.ih_q : rsp.oh_q;
  assign depth_m2 = depth - cnt_t'(2);

  assign in_ready   = (state == ST_IDLE);
  assign res_count  = cnt;
  assign res_status = drop_flags[1] ? STATUS_RANGE : (drop_flags[0] ? STATUS_FULL : STATUS_OK);

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    edge_count_next = edge_count;
    drop_flags_next = drop_flags;
    add_f_next      = add_f;
    add_t_next      = add_t;
    scan_i_next     = scan_i;
    fin_next        = fin;
    cnt_next        = cnt;
    dir_next        = dir;
    depth_next      = depth;
    top_node_next   = top_node;
    top_ptr_next    = top_ptr;
    cur_t_next      = cur_t;
    res_valid       = 1'b0;
    req             = '0;

    case (state)
      ST_CLEAR: begin
        req.oh_we      = 1'b1;
        req.ih_we      = 1'b1;
        req.oh_waddr   = clr_addr;
        req.ih_waddr   = clr_addr;
        req.head_wdata = NULL_LINK;
        req.sr_we      = 1'b1;
        req.sf_we      = 1'b1;
        req.seen_waddr = clr_addr;
        req.seen_wdata = 1'b0;
        clr_addr_next  = clr_addr + node_t'(1);
        if (clr_addr == node_t'(MAX_NODES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.oh_raddr = from_m1[NODE_W-1:0];
        req.ih_raddr = to_m1[NODE_W-1:0];
        if (in_valid) begin
          if (opcode) begin
            scan_i_next = '0;
            fin_next    = '0;
            cnt_next    = '0;
            dir_next    = 1'b1;
            state_next  = ST_RSCAN;
          end else if (bad_node) begin
            drop_flags_next = drop_flags | 2'b10;
          end else if (edge_count[EIDX_W]) begin
            drop_flags_next = drop_flags | 2'b01;
          end else begin
            add_f_next = from_m1[NODE_W-1:0];
            add_t_next = to_m1[NODE_W-1:0];
            state_next = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        // Head reads issued in the idle cycle are back; link the new edge in front.
        req.edge_we     = 1'b1;
        req.edge_waddr  = edge_count[EIDX_W-1:0];
        req.fwd_wdata   = {rsp.oh_q, add_t};
        req.rev_wdata   = {rsp.ih_q, add_f};
        req.oh_we       = 1'b1;
        req.ih_we       = 1'b1;
        req.oh_waddr    = add_f;
        req.ih_waddr    = add_t;
        req.head_wdata  = edge_count;
        edge_count_next = edge_count + link_t'(1);
        state_next      = ST_IDLE;
      end
      ST_RSCAN: begin
        req.seen_raddr = scan_i[NODE_W-1:0];
        req.ih_raddr   = scan_i[NODE_W-1:0];
        if (scan_i == n) begin
          scan_i_next = fin;
          dir_next    = 1'b0;
          state_next  = ST_FSCAN;
        end else begin
          state_next = ST_RSTART;
        end
      end
      ST_RSTART: begin
        if (!rsp.sr_q) begin
          req.sr_we      = 1'b1;
          req.seen_waddr = scan_i[NODE_W-1:0];
          req.seen_wdata = 1'b1;
          top_node_next  = scan_i[NODE_W-1:0];
          top_ptr_next   = rsp.ih_q;
          depth_next     = cnt_t'(1);
          state_next     = ST_STEP;
        end else begin
          scan_i_next = scan_i + cnt_t'(1);
          state_next  = ST_RSCAN;
        end
      end
      ST_STEP: begin
        req.edge_raddr = top_ptr[EIDX_W-1:0];
        req.stk_raddr  = depth_m2[NODE_W-1:0];
        if (top_ptr[EIDX_W]) begin
          if (dir && fin < cnt_t'(MAX_NODES)) begin
            req.fin_we    = 1'b1;
            req.fin_waddr = fin[NODE_W-1:0];
            req.fin_wdata = top_node;
            fin_next      = fin + cnt_t'(1);
          end
          if (depth == cnt_t'(1)) begin
            depth_next = '0;
            if (dir) begin
              scan_i_next = scan_i + cnt_t'(1);
              state_next  = ST_RSCAN;
            end else begin
              scan_i_next = scan_i - cnt_t'(1);
              state_next  = ST_FSCAN;
            end
          end else begin
            depth_next = depth - cnt_t'(1);
            state_next = ST_POP;
          end
        end else begin
          state_next = ST_EDGE;
        end
      end
      ST_POP: begin
        top_node_next = rsp.stk_q[NODE_W-1:0];
        top_ptr_next  = rsp.stk_q[ENTRY_W-1:NODE_W];
        state_next    = ST_STEP;
      end
      ST_EDGE: begin
        top_ptr_next   = edge_q[ENTRY_W-1:NODE_W];
        cur_t_next     = edge_q[NODE_W-1:0];
        req.seen_raddr = edge_q[NODE_W-1:0];
        req.oh_raddr   = edge_q[NODE_W-1:0];
        req.ih_raddr   = edge_q[NODE_W-1:0];
        state_next     = ST_CHK;
      end
      ST_CHK: begin
        // Descend only into live, unvisited nodes while the stack has room.
        if ({1'b0, cur_t} < n && !seen_q && depth < cnt_t'(MAX_NODES)) begin
          req.sr_we      = dir;
          req.sf_we      = !dir;
          req.seen_waddr = cur_t;
          req.seen_wdata = 1'b1;
          req.stk_we     = 1'b1;
          req.stk_waddr  = depth_m2[NODE_W-1:0] + node_t'(1);
          req.stk_wdata  = {top_ptr, top_node};
          top_node_next  = cur_t;
          top_ptr_next   = head_q;
          depth_next     = depth + cnt_t'(1);
        end
        state_next = ST_STEP;
      end
      ST_FSCAN: begin
        req.fin_raddr = scan_i[NODE_W-1:0] - node_t'(1);
        if (scan_i == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FREAD;
        end
      end
      ST_FREAD: begin
        cur_t_next     = rsp.fin_q;
        req.seen_raddr = rsp.fin_q;
        req.oh_raddr   = rsp.fin_q;
        state_next     = ST_FSTART;
      end
      ST_FSTART: begin
        if ({1'b0, cur_t} < n && !rsp.sf_q) begin
          req.sf_we      = 1'b1;
          req.seen_waddr = cur_t;
          req.seen_wdata = 1'b1;
          cnt_next       = cnt + cnt_t'(1);
          top_node_next  = cur_t;
          top_ptr_next   = rsp.oh_q;
          depth_next     = cnt_t'(1);
          state_next     = ST_STEP;
        end else begin
          scan_i_next = scan_i - cnt_t'(1);
          state_next  = ST_FSCAN;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          res_valid       = 1'b1;
          edge_count_next = '0;
          drop_flags_next = '0;
          clr_addr_next   = '0;
          state_next      = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      edge_count <= '0;
      drop_flags <= '0;
      depth      <= '0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      edge_count <= edge_count_next;
      drop_flags <= drop_flags_next;
      depth      <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    add_f    <= add_f_next;
    add_t    <= add_t_next;
    scan_i   <= scan_i_next;
    fin      <= fin_next;
    cnt      <= cnt_next;
    dir      <= dir_next;
    top_node <= top_node_next;
    top_ptr  <= top_ptr_next;
    cur_t    <= cur_t_next;
  end
endmodule
`default_nettype wire

[src/scc_counter_top.sv]
// Top level of the strongly connected component counter.
//
//   port group   dir  word contents
//   s_*          in   tuser: opcode; tdata: edge_from, edge_to
//   m_*          out  tdata: component_count, status
//   cfg_*        in   node_count
//
// A compute word walks both graphs through single-port-read memories: a reverse
// pass over the nodes, a forward pass over the finish-order entries, each
// following edges and finishing nodes, then a clearing pass over all 1024
// entries of the head and mark memories. The same clearing pass runs after
// reset; s_tready stays low during it. A result waiting on m_tready does not
// stop edge loading, only the next compute from finishing.
`default_nettype none
module scc_counter_top import scc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [10:0] edge_from, [21:11] edge_to
  input  wire logic [0:0]  s_tuser,   // [0] opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [10:0] component_count, [12:11] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data   // node_count
);
  cnt_t       node_count;
  cnt_t       n;
  mem_req_t   req;
  mem_rsp_t   rsp;
  logic       res_valid, res_ready;
  cnt_t       res_count;
  logic [1:0] res_status;
  cnt_t       out_count;
  logic [1:0] out_status;

  assign cfg_ready = 1'b1;
  assign n = (node_count > cnt_t'(MAX_NODES)) ? cnt_t'(MAX_NODES) : node_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= cnt_t'(MAX_NODES);
    end else if (cfg_valid) begin
      node_count <= cfg_data;
    end
  end

  scc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tuser[0]),
    .edge_from  (s_tdata[10:0]),
    .edge_to    (s_tdata[21:11]),
    .n          (n),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res_count  (res_count),
    .res_status (res_status),
    .req        (req),
    .rsp        (rsp)
  );

  scc_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_out_head (
    .clk(clk), .we(req.oh_we), .waddr(req.oh_waddr), .wdata(req.head_wdata),
    .raddr(req.oh_raddr), .rdata(rsp.oh_q));
  scc_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_in_head (
    .clk(clk), .we(req.ih_we), .waddr(req.ih_waddr), .wdata(req.head_wdata),
    .raddr(req.ih_raddr), .rdata(rsp.ih_q));
  scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_seen_rev (
    .clk(clk), .we(req.sr_we), .waddr(req.seen_waddr), .wdata(req.seen_wdata),
    .raddr(req.seen_raddr), .rdata(rsp.sr_q));
  scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_seen_fwd (
    .clk(clk), .we(req.sf_we), .waddr(req.seen_waddr), .wdata(req.seen_wdata),
    .raddr(req.seen_raddr), .rdata(rsp.sf_q));
  scc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EDGES)) u_fwd_edge (
    .clk(clk), .we(req.edge_we), .waddr(req.edge_waddr), .wdata(req.fwd_wdata),
    .raddr(req.edge_raddr), .rdata(rsp.fwd_q));
  scc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EDGES)) u_rev_edge (
    .clk(clk), .we(req.edge_we), .waddr(req.edge_waddr), .wdata(req.rev_wdata),
    .raddr(req.edge_raddr), .rdata(rsp.rev_q));
  scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_finish (
    .clk(clk), .we(req.fin_we), .waddr(req.fin_waddr), .wdata(req.fin_wdata),
    .raddr(req.fin_raddr), .rdata(rsp.fin_q));
  scc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NODES)) u_stack (
    .clk(clk), .we(req.stk_we), .waddr(req.stk_waddr), .wdata(req.stk_wdata),
    .raddr(req.stk_raddr), .rdata(rsp.stk_q));

  // Output register; the sequencer only finishes when it is free or draining.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_count  <= res_count;
      out_status <= res_status;
    end
  end

  assign m_tdata = {3'b000, out_status, out_count};
endmodule
`default_nettype wire

[src/scc_counter_checks.sv]
// Port-level checks for the component counter, bound to the top level.
`default_nettype none
module scc_counter_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("output or input open right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[12:11] != 2'b11)
    else $error("illegal status code");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:0] <= 11'd1024 && m_tdata[15:13] == 3'b000)
    else $error("component count out of range");
endmodule

bind scc_counter_top scc_counter_checks u_checks (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the strongly connected component counter.
module tb;
  import scc_pkg::*;

  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [10:0] edge_from, [21:11] edge_to
  logic [0:0]  s_tuser;   // [0] opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [10:0] component_count, [12:11] status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  scc_counter_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow copy of the graph, kept as plain adjacency queues.
  int unsigned nodes_setting;
  int unsigned edge_total;
  logic [1:0]  drops;
  int          fwd_adj[MAX_NODES][$];
  int          rev_adj[MAX_NODES][$];

  logic [12:0] count_queue[$];
  int          mismatches;
  int          hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("scc_counter_top test failed");
    $finish;
  end

  function automatic void clear_shadow();
    for (int i = 0; i < MAX_NODES; i++) begin
      fwd_adj[i].delete();
      rev_adj[i].delete();
    end
    edge_total = 0;
    drops = 2'b00;
  endfunction

  // Kosaraju count over the shadow lists; lists are newest-first like the block.
  function automatic logic [12:0] scc_predict();
    int unsigned n;
    bit          seen_r[MAX_NODES];
    bit          seen_f[MAX_NODES];
    int          order[MAX_NODES];
    int          n_order;
    int          stk_node[MAX_NODES];
    int          stk_pos[MAX_NODES];
    int          sp;
    int          comps;
    int          v;
    int          t;
    int          k;
    int          top;
    logic [1:0]  st;
    n = nodes_setting > MAX_NODES ? MAX_NODES : nodes_setting;
    comps = 0;
    n_order = 0;
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < (pass == 0 ? int'(n) : n_order); i++) begin
        if (pass == 0) begin
          v = i;
          if (seen_r[v]) continue;
          seen_r[v] = 1;
        end else begin
          v = order[n_order - 1 - i];
          if (v >= int'(n) || seen_f[v]) continue;
          seen_f[v] = 1;
          comps++;
        end
        stk_node[0] = v;
        stk_pos[0] = 0;
        sp = 1;
        while (sp > 0) begin
          top = sp - 1;
          k = stk_pos[top];
          v = stk_node[top];
          if (pass == 0 ? k >= rev_adj[v].size() : k >= fwd_adj[v].size()) begin
            if (pass == 0) begin
              order[n_order] = v;
              n_order++;
            end
            sp--;
          end else begin
            stk_pos[top] = k + 1;
            t = pass == 0 ? rev_adj[v][rev_adj[v].size() - 1 - k]
                          : fwd_adj[v][fwd_adj[v].size() - 1 - k];
            if (t < int'(n) && !(pass == 0 ? seen_r[t] : seen_f[t]) &&
                sp < MAX_NODES) begin
              if (pass == 0) seen_r[t] = 1; else seen_f[t] = 1;
              stk_node[sp] = t;
              stk_pos[sp] = 0;
              sp++;
            end
          end
        end
      end
    end
    st = drops[1] ? STATUS_RANGE : (drops[0] ? STATUS_FULL : STATUS_OK);
    return {st, 11'(comps)};
  endfunction

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) g = 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_word(logic op, logic [10:0] src, logic [10:0] dst);
    int unsigned n;
    n = nodes_setting > MAX_NODES ? MAX_NODES : nodes_setting;
    idle_gap();
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, dst, src};
    @(posedge clk iff s_tready);
    if (op == OP_COMPUTE) begin
      count_queue.insert(count_queue.size(), scc_predict());
      clear_shadow();
    end else if (src == 0 || src > n || dst == 0 || dst > n) begin
      drops[1] = 1'b1;
    end else if (edge_total >= MAX_EDGES) begin
      drops[0] = 1'b1;
    end else begin
      fwd_adj[src - 1].insert(fwd_adj[src - 1].size(), int'(dst) - 1);
      rev_adj[dst - 1].insert(rev_adj[dst - 1].size(), int'(src) - 1);
      edge_total++;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (count_queue.size() > 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic set_nodes(logic [10:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    nodes_setting = value;
  endtask

  task automatic random_graph(int edges, int span, int noise_pct);
    logic [10:0] a;
    logic [10:0] b;
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        a = 11'($urandom_range(0, 2047));
        b = 11'($urandom_range(0, 2047));
      end else begin
        a = 11'($urandom_range(1, span));
        b = 11'($urandom_range(1, span));
      end
      send_word(OP_EDGE, a, b);
    end
    send_word(OP_COMPUTE, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
  endtask

  task automatic test_directed();
    set_nodes(11'd4);
    send_word(OP_COMPUTE, 11'd0, 11'd0);
    send_word(OP_EDGE, 11'd1, 11'd2);
    send_word(OP_EDGE, 11'd2, 11'd1);
    send_word(OP_EDGE, 11'd3, 11'd3);
    send_word(OP_EDGE, 11'd2, 11'd4);
    send_word(OP_COMPUTE, 11'd0, 11'd0);
    // Out-of-range nodes in both fields.
    send_word(OP_EDGE, 11'd0, 11'd1);
    send_word(OP_EDGE, 11'd1, 11'd5);
    send_word(OP_EDGE, 11'h7ff, 11'h7ff);
    send_word(OP_COMPUTE, 11'h7ff, 11'h7ff);
    set_nodes(11'd0);
    send_word(OP_EDGE, 11'd1, 11'd1);
    send_word(OP_COMPUTE, 11'd0, 11'd0);
    set_nodes(11'h7ff);
    send_word(OP_EDGE, 11'd1024, 11'd1);
    send_word(OP_EDGE, 11'd1, 11'd1024);
    send_word(OP_EDGE, 11'd1025, 11'd1);
    send_word(OP_COMPUTE, 11'd0, 11'd0);
    set_nodes(11'd1);
    send_word(OP_COMPUTE, 11'd0, 11'd0);
  endtask

  // Edges loaded with a large count, then the count is lowered before compute.
  task automatic test_shrink();
    set_nodes(11'd8);
    for (int i = 0; i < 12; i++)
      send_word(OP_EDGE, 11'($urandom_range(1, 8)), 11'($urandom_range(1, 8)));
    set_nodes(11'd4);
    send_word(OP_COMPUTE, 11'd0, 11'd0);
  endtask

  // The receiver holds off long enough for a second result to back up.
  task automatic test_backpressure();
    set_nodes(11'd6);
    hold_cycles = 4000;
    for (int r = 0; r < 6; r++) random_graph(5, 6, 0);
    drain();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 1380) begin
      case ($urandom_range(0, 5))
        0: set_nodes(11'($urandom_range(1, 16)));
        1: set_nodes(11'($urandom_range(17, 1024)));
        2: set_nodes(11'($urandom_range(1025, 2047)));
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        random_graph(30, 1024, 5);
        sent += 31;
      end else begin
        random_graph(12, 12, 10);
        sent += 13;
      end
    end
  endtask

  // Result checker with random receiver stalls.
  always @(posedge clk) begin
    logic [12:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (count_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", m_tdata);
        end else begin
          want = count_queue.pop_front();
          if (m_tdata[10:0] !== want[10:0] || m_tdata[12:11] !== want[12:11] ||
              m_tdata[15:13] !== 3'b000) begin
            mismatches++;
            if (mismatches <= 10)
              $display("count/status expected %0d/%0d got %0d/%0d", want[10:0],
                       want[12:11], m_tdata[10:0], m_tdata[12:11]);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    mismatches = 0;
    hold_cycles = 0;
    nodes_setting = 1024;
    clear_shadow();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_shrink();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && count_queue.size() == 0)
      $display("scc_counter_top test passed");
    else
      $display("scc_counter_top test failed");
    $finish;
  end
endmodule
